### hw/rtl/smf_pkg.sv
// shared types, constants and helpers for the sliding median filter
package smf_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAX_WINDOW = 7;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned MID_IDX    = MAX_WINDOW / 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef sample_t                    win_t [MAX_WINDOW];

  localparam len_t    LEN_RESET  = len_t'(3);
  localparam len_t    LEN_MIN    = len_t'(3);
  localparam len_t    LEN_MAX    = len_t'(7);
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // odd lengths from three up to the window depth filter, the rest pass through
  function automatic logic len_valid(input len_t len);
    len_valid = (len >= LEN_MIN) && (len <= LEN_MAX) && len[0]
                && ({1'b0, len} <= (LEN_W+1)'(MAX_WINDOW));
  endfunction

endpackage

### hw/rtl/sliding_median_filter_unit.sv
// sliding median filter top level: window shift, input stage and result register
//
//   port group | direction | handshake           | payload
//   in_        | in        | in_valid / in_stall  | in_sample (16b signed)
//   out_       | out       | out_valid / out_stall| out_median (16b signed)
//   cfg_       | in        | cfg_wr_en            | cfg_wr_data (window length, 3b)
//
// one beat per cycle sustained while out_stall is low; each beat passes through
// the input stage, then the sorting network into the result register
// reset clears the window to zeros and sets the window length to three
// in_stall rises only while both the input stage and the result register are
// full and out_stall is high
module sliding_median_filter_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  smf_pkg::len_t    cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  smf_pkg::sample_t in_sample,
  output logic             out_valid,
  input  logic             out_stall,
  output smf_pkg::sample_t out_median
);

  smf_pkg::len_t    len_r;
  smf_pkg::win_t    win_r;
  logic             stg_valid_r;
  logic             stg_pass_r;
  smf_pkg::len_t    stg_len_r;
  smf_pkg::sample_t stg_sample_r;
  logic             out_valid_r;
  smf_pkg::sample_t out_median_r;

  logic             in_acc;
  logic             stg_adv;
  logic             len_ok;
  smf_pkg::sample_t net_median;

  assign len_ok   = smf_pkg::len_valid(len_r);
  assign stg_adv  = stg_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= smf_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  // window shifts only on filtering beats, newest sample at slot zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < smf_pkg::MAX_WINDOW; k++) begin
        win_r[k] <= '0;
      end
    end else if (in_acc && len_ok) begin
      win_r[0] <= in_sample;
      for (int k = 1; k < smf_pkg::MAX_WINDOW; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_acc) begin
      stg_valid_r <= 1'b1;
    end else if (stg_adv) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_pass_r   <= !len_ok;
      stg_len_r    <= len_r;
      stg_sample_r <= in_sample;
    end
  end

  smf_median_net u_median_net (
    .win    (win_r),
    .len    (stg_len_r),
    .median (net_median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_median_r <= stg_pass_r ? stg_sample_r : net_median;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

### hw/rtl/smf_median_net.sv
// median of the newest window samples through a padded odd-even sorting network
module smf_median_net (
  input  smf_pkg::win_t    win,
  input  smf_pkg::len_t    len,
  output smf_pkg::sample_t median
);

  smf_pkg::win_t padded;
  smf_pkg::win_t sorted;

  // unused slots alternate between the largest and smallest value, equal in
  // number, so the middle of the full sort is the median of the used slots
  always_comb begin
    for (int k = 0; k < smf_pkg::MAX_WINDOW; k++) begin
      if (k < int'(len)) begin
        padded[k] = win[k];
      end else if ((k % 2) == 1) begin
        padded[k] = smf_pkg::SAMPLE_MAX;
      end else begin
        padded[k] = smf_pkg::SAMPLE_MIN;
      end
    end
  end

  always_comb begin
    smf_pkg::sample_t tmp;
    tmp    = '0;
    sorted = padded;
    for (int r = 0; r < smf_pkg::MAX_WINDOW; r++) begin
      for (int i = r % 2; i + 1 < smf_pkg::MAX_WINDOW; i += 2) begin
        if (sorted[i] > sorted[i+1]) begin
          tmp         = sorted[i];
          sorted[i]   = sorted[i+1];
          sorted[i+1] = tmp;
        end
      end
    end
  end

  assign median = sorted[smf_pkg::MID_IDX];

endmodule
